### sv/piu_pkg.sv
// ----------------------------------------------------------------------------
// piu_pkg
// Shared types and constants of the pin interrupt event unit.
// ----------------------------------------------------------------------------
`default_nettype none

package piu_pkg;

  // block dimensions
  localparam int unsigned NumChannels = 6;
  localparam int unsigned NumPins     = 34;
  localparam int unsigned PinIdxW     = 6;
  localparam int unsigned PinSpan     = 2 ** PinIdxW;
  localparam int unsigned ModeW       = 3;
  localparam int unsigned EvW         = 3;
  localparam int unsigned HoldW       = 8;
  localparam int unsigned ChanIdW     = 3;
  localparam int unsigned CfgIdxW     = 4;
  localparam int unsigned CfgDataW    = NumChannels * PinIdxW;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegPinSelect = 4'd0;
  localparam logic [CfgIdxW-1:0] RegModes     = 4'd1;
  localparam logic [CfgIdxW-1:0] RegEnable    = 4'd2;
  localparam logic [CfgIdxW-1:0] RegHoldoff   = 4'd3;

  // channel modes
  localparam logic [ModeW-1:0] ModeLow    = 3'd0;
  localparam logic [ModeW-1:0] ModeHigh   = 3'd1;
  localparam logic [ModeW-1:0] ModeChange = 3'd2;
  localparam logic [ModeW-1:0] ModeRise   = 3'd3;
  localparam logic [ModeW-1:0] ModeFall   = 3'd4;

  // event codes
  localparam logic [EvW-1:0] EvLow  = 3'd0;
  localparam logic [EvW-1:0] EvHigh = 3'd1;
  localparam logic [EvW-1:0] EvBoth = 3'd2;
  localparam logic [EvW-1:0] EvRise = 3'd3;
  localparam logic [EvW-1:0] EvFall = 3'd4;

  localparam logic [HoldW-1:0] HoldoffReset = 8'd50;
  localparam logic [HoldW-1:0] HoldoffMask  = 8'hFF;

  // one tick request
  typedef struct packed {
    logic [NumPins-1:0] pin_levels;
    logic               drain;
  } tick_t;

  // one reported event
  typedef struct packed {
    logic [ChanIdW-1:0] channel_id;
    logic [EvW-1:0]     event_type;
    logic               last;
  } result_t;

  // snapshot of the pending events taken by one drain
  typedef struct packed {
    logic [NumChannels-1:0]     mask;
    logic [NumChannels*EvW-1:0] codes;
  } job_t;

endpackage

`default_nettype wire

### sv/piu_front.sv
// ----------------------------------------------------------------------------
// piu_front
// Configuration registers and per-channel tick update; hands drain snapshots
// to the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module piu_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire piu_pkg::tick_t                tick_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [piu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [piu_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                               job_push_o,
  output piu_pkg::job_t                      job_o
);
  import piu_pkg::*;

  // configuration registers
  logic [NumChannels*PinIdxW-1:0] pin_sel_q;
  logic [NumChannels*ModeW-1:0]   modes_q;
  logic [NumChannels-1:0]         enable_q;
  logic [HoldW-1:0]               holdoff_q;

  // channel state
  logic [NumChannels-1:0] prev_q, prev_d;
  logic [NumChannels-1:0] rise_q, rise_d;
  logic [NumChannels-1:0] fall_q, fall_d;
  logic [NumChannels-1:0] pend_q, pend_d;
  logic [EvW-1:0]         code_q [NumChannels];
  logic [EvW-1:0]         code_d [NumChannels];
  logic [HoldW-1:0]       hold_q [NumChannels];
  logic [HoldW-1:0]       hold_d [NumChannels];

  logic [HoldW-1:0] hold_load;
  logic             en_write;
  logic [NumChannels-1:0] en_new;

  // a zero holdoff behaves as one tick
  assign hold_load = (holdoff_q == '0) ? HoldW'(1) : (holdoff_q & HoldoffMask);
  assign en_write  = cfg_we_i && (cfg_index_i == RegEnable);
  assign en_new    = cfg_data_i[NumChannels-1:0];

  // per-channel update for one tick
  always_comb begin
    logic [PinSpan-1:0] lv_ext;
    logic [PinIdxW-1:0] pin;
    logic [ModeW-1:0]   mode;
    logic [HoldW-1:0]   hold_n;
    logic [EvW-1:0]     ev, code_n;
    logic               lvl, rise, fall, fire, pend;

    lv_ext = PinSpan'(tick_i.pin_levels);
    job_o  = '0;
    for (int c = 0; c < NumChannels; c++) begin
      rise   = rise_q[c];
      fall   = fall_q[c];
      pend   = pend_q[c];
      code_n = code_q[c];
      hold_n = hold_q[c];
      // holdoff countdown, release clears the latches
      if (hold_q[c] != '0) begin
        hold_n = hold_q[c] - 1'b1;
        if (hold_n == '0) begin
          rise = 1'b0;
          fall = 1'b0;
        end
      end
      // edge detection on the selected pin
      pin  = pin_sel_q[c*PinIdxW +: PinIdxW];
      lvl  = lv_ext[pin];
      if (!prev_q[c] && lvl) rise = 1'b1;
      if (prev_q[c] && !lvl) fall = 1'b1;
      // firing decision
      mode = modes_q[c*ModeW +: ModeW];
      fire = 1'b0;
      ev   = EvLow;
      if (enable_q[c] && (hold_n == '0)) begin
        unique case (mode)
          ModeLow: begin
            fire = !lvl;
            ev   = EvLow;
          end
          ModeHigh: begin
            fire = lvl;
            ev   = EvHigh;
          end
          ModeChange: begin
            fire = rise || fall;
            ev   = (rise && fall) ? EvBoth : (rise ? EvRise : EvFall);
          end
          ModeRise: begin
            fire = rise;
            ev   = EvRise;
          end
          ModeFall: begin
            fire = fall;
            ev   = EvFall;
          end
          default: begin
            fire = 1'b0;
            ev   = EvLow;
          end
        endcase
      end
      if (fire) begin
        pend   = 1'b1;
        code_n = ev;
        hold_n = hold_load;
      end
      // drain snapshot, then clear
      if (tick_i.drain) begin
        job_o.mask[c]               = pend;
        job_o.codes[c*EvW +: EvW]   = code_n;
        pend   = 1'b0;
        code_n = EvLow;
      end

      if (accept_i) begin
        prev_d[c] = lvl;
        rise_d[c] = rise;
        fall_d[c] = fall;
        pend_d[c] = pend;
        code_d[c] = code_n;
        hold_d[c] = hold_n;
      end else begin
        prev_d[c] = prev_q[c];
        rise_d[c] = rise_q[c];
        fall_d[c] = fall_q[c];
        pend_d[c] = pend_q[c];
        code_d[c] = code_q[c];
        hold_d[c] = hold_q[c];
      end
      // enable write clears latches of old and new enabled channels
      if (en_write && (enable_q[c] || en_new[c])) begin
        rise_d[c] = 1'b0;
        fall_d[c] = 1'b0;
      end
    end
  end

  assign job_push_o = accept_i && tick_i.drain && (job_o.mask != '0);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_sel_q <= '0;
      modes_q   <= '0;
      enable_q  <= '0;
      holdoff_q <= HoldoffReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegPinSelect: pin_sel_q <= cfg_data_i;
        RegModes:     modes_q   <= cfg_data_i[NumChannels*ModeW-1:0];
        RegEnable:    enable_q  <= en_new;
        RegHoldoff:   holdoff_q <= cfg_data_i[HoldW-1:0];
        default:      ;
      endcase
    end
  end

  // channel state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      rise_q <= '0;
      fall_q <= '0;
      pend_q <= '0;
      for (int c = 0; c < NumChannels; c++) begin
        code_q[c] <= '0;
        hold_q[c] <= '0;
      end
    end else begin
      prev_q <= prev_d;
      rise_q <= rise_d;
      fall_q <= fall_d;
      pend_q <= pend_d;
      for (int c = 0; c < NumChannels; c++) begin
        code_q[c] <= code_d[c];
        hold_q[c] <= hold_d[c];
      end
    end
  end

endmodule

`default_nettype wire

### sv/piu_job_queue.sv
// ----------------------------------------------------------------------------
// piu_job_queue
// Short queue of drain snapshots between the tick front and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module piu_job_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_en_i,
  input  wire piu_pkg::job_t  wr_data_i,
  output logic                full_o,
  input  wire logic           rd_en_i,
  output piu_pkg::job_t       rd_data_o,
  output logic                empty_o
);
  import piu_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_wr, do_rd;

  assign full_o    = (count_q == CW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/piu_emitter.sv
// ----------------------------------------------------------------------------
// piu_emitter
// Walks one drain snapshot in channel order and presents one event at a time
// through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module piu_emitter (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_empty_i,
  input  wire piu_pkg::job_t  job_i,
  output logic                job_pop_o,
  input  wire logic           pop,
  output logic                empty,
  output piu_pkg::result_t    result_o
);
  import piu_pkg::*;

  logic [NumChannels-1:0]     mask_q;
  logic [NumChannels*EvW-1:0] codes_q;
  logic                       out_valid_q;
  result_t                    out_q;
  logic                       slot_free;
  logic [ChanIdW-1:0]         sel_id;
  logic [NumChannels-1:0]     rest_mask;

  assign slot_free = !out_valid_q || pop;
  assign job_pop_o = (mask_q == '0) && !job_empty_i;
  assign empty     = !out_valid_q;
  assign result_o  = out_q;

  // lowest pending channel of the snapshot
  always_comb begin
    sel_id    = '0;
    rest_mask = mask_q;
    for (int c = NumChannels - 1; c >= 0; c--) begin
      if (mask_q[c]) sel_id = ChanIdW'(c);
    end
    rest_mask[sel_id] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      codes_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // load next snapshot once the current one is done
      if (job_pop_o) begin
        mask_q  <= job_i.mask;
        codes_q <= job_i.codes;
      end else if ((mask_q != '0) && slot_free) begin
        mask_q <= rest_mask;
      end
      // output register
      if ((mask_q != '0) && slot_free) begin
        out_valid_q      <= 1'b1;
        out_q.channel_id <= sel_id;
        out_q.event_type <= codes_q[sel_id*EvW +: EvW];
        out_q.last       <= (rest_mask == '0);
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### sv/pin_interrupt_event_unit.sv
// ----------------------------------------------------------------------------
// pin_interrupt_event_unit
// Six-channel pin interrupt unit with level and edge modes, holdoff masking
// and drained event reporting.
// ----------------------------------------------------------------------------
// Each accepted tick makes every channel sample its selected pin, update
// its latches and holdoff counter, and possibly fire. A tick with drain
// set snapshots any pending events into a queue of JOB_DEPTH snapshots;
// the emitter loads a snapshot and then presents its events one at a time,
// each once the output register is free. Ticks keep being taken while
// results wait, and full rises only when the snapshot queue is full. The
// configuration port never stalls; write it only while the unit is idle.
// A write to the enable register clears the latches of every channel that
// was or becomes enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module pin_interrupt_event_unit #(
  parameter int unsigned JOB_DEPTH = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire piu_pkg::tick_t                tick_i,
  output logic                               empty,
  input  wire logic                          pop,
  output piu_pkg::result_t                   result_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [piu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [piu_pkg::CfgDataW-1:0]  cfg_data_i
);
  import piu_pkg::*;

  logic accept;
  logic job_push, job_pop, job_empty;
  job_t job_in, job_out;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // tick front
  piu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .tick_i      (tick_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  // snapshot queue
  piu_job_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (job_push),
    .wr_data_i (job_in),
    .full_o    (full),
    .rd_en_i   (job_pop),
    .rd_data_o (job_out),
    .empty_o   (job_empty)
  );

  // event emitter
  piu_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .pop         (pop),
    .empty       (empty),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

### sim/tb_pin_interrupt_event_unit.sv
// ----------------------------------------------------------------------------
// tb_pin_interrupt_event_unit
// Self-checking testbench for the six-channel pin interrupt event unit.
// ----------------------------------------------------------------------------
// Ticks are pushed through the input queue side and every drained event is
// compared, field by field, against a cycle-free software copy of the
// channels (latches, holdoff masking, pending codes). A short table of
// directed rows comes first; then random configurations, each followed by a
// run of random ticks. A later phase stalls the reader for a long stretch so
// that the drain snapshots back up and the unit raises full; a last few
// ticks run with the longest holdoff.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pin_interrupt_event_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import piu_pkg::*;

  // run limits and pacing
  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned LatencyPad   = 12;
  localparam int unsigned PressureHold = 400;
  localparam int unsigned RandomTicks  = 70;
  localparam int unsigned MaxPrinted   = 20;

  // codes the package does not name
  localparam logic [CfgIdxW-1:0] RegNone = 4'd15;
  localparam logic [ModeW-1:0]   ModeBad = 3'd7;
  localparam logic [NumPins-1:0] AllPins = '1;

  typedef enum logic [1:0] {RowCfg, RowTick, RowRun} row_kind_e;

  // one line of the directed table; RowRun repeats its tick data times
  typedef struct {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    tick_t               tk;
    bit                  typed;
    int unsigned         n_exp;
    result_t             exp_ev;
  } stim_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             push        = 1'b0;
  logic             full;
  tick_t            tick_i      = '0;
  logic             empty;
  logic             pop         = 1'b0;
  result_t          result_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // software copy of the channels
  logic [CfgDataW-1:0]          sel_cfg  = '0;
  logic [NumChannels*ModeW-1:0] mode_cfg = '0;
  logic [NumChannels-1:0]       en_cfg   = '0;
  logic [HoldW-1:0]             hold_cfg = HoldoffReset;
  logic [NumChannels-1:0]       lvl_prev  = '0;
  logic [NumChannels-1:0]       rise_seen = '0;
  logic [NumChannels-1:0]       fall_seen = '0;
  logic [NumChannels-1:0]       pend      = '0;
  logic [EvW-1:0]               pend_code [NumChannels] = '{default: '0};
  logic [HoldW-1:0]             mask_left [NumChannels] = '{default: '0};

  result_t     fired_now [$];
  result_t     event_q [$];
  result_t     want_ev;
  stim_row_t   dir_rows [$];

  bit          hold_req = 1'b0;
  bit          steady   = 1'b0;
  int unsigned errors      = 0;
  int unsigned cycles      = 0;
  int unsigned full_stalls = 0;
  int unsigned ticks_sent  = 0;
  int unsigned drains      = 0;
  int unsigned cfg_writes  = 0;
  int unsigned checked     = 0;

  pin_interrupt_event_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .tick_i      (tick_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MaxPrinted) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  // gap length: none in steady phases, else mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [NumPins-1:0] rand_levels();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[NumPins-1:0];
  endfunction

  // register write as seen by the channels
  function automatic void apply_reg_write(input logic [CfgIdxW-1:0] idx,
                                          input logic [CfgDataW-1:0] data);
    unique case (idx)
      RegPinSelect: sel_cfg = data;
      RegModes:     mode_cfg = data[NumChannels*ModeW-1:0];
      RegEnable: begin
        rise_seen &= ~(en_cfg | data[NumChannels-1:0]);
        fall_seen &= ~(en_cfg | data[NumChannels-1:0]);
        en_cfg = data[NumChannels-1:0];
      end
      RegHoldoff:   hold_cfg = data[HoldW-1:0];
      default: ;
    endcase
  endfunction

  // one tick through every channel, drained events land in fired_now
  function automatic void advance_tick(input tick_t t);
    logic [PinIdxW-1:0] pin;
    logic               lvl;
    logic [ModeW-1:0]   mode;
    logic               fire;
    logic [EvW-1:0]     code;
    result_t            ev;
    fired_now.delete();
    for (int c = 0; c < NumChannels; c++) begin
      // holdoff countdown, latches cleared when it runs out
      if (mask_left[c] != 0) begin
        mask_left[c] = mask_left[c] - 1'b1;
        if (mask_left[c] == 0) begin
          rise_seen[c] = 1'b0;
          fall_seen[c] = 1'b0;
        end
      end
      // pins beyond the vector read as low
      pin = sel_cfg[c*PinIdxW +: PinIdxW];
      lvl = (pin < NumPins) ? t.pin_levels[pin] : 1'b0;
      if (!lvl_prev[c] && lvl) rise_seen[c] = 1'b1;
      if (lvl_prev[c] && !lvl) fall_seen[c] = 1'b1;
      lvl_prev[c] = lvl;
      if (!en_cfg[c] || mask_left[c] != 0) continue;
      mode = mode_cfg[c*ModeW +: ModeW];
      fire = 1'b0;
      code = EvLow;
      unique case (mode)
        ModeLow: begin
          fire = !lvl;
          code = EvLow;
        end
        ModeHigh: begin
          fire = lvl;
          code = EvHigh;
        end
        ModeChange: begin
          fire = rise_seen[c] | fall_seen[c];
          if (rise_seen[c] && fall_seen[c]) code = EvBoth;
          else if (rise_seen[c]) code = EvRise;
          else code = EvFall;
        end
        ModeRise: begin
          fire = rise_seen[c];
          code = EvRise;
        end
        ModeFall: begin
          fire = fall_seen[c];
          code = EvFall;
        end
        default: ;
      endcase
      // newer event overwrites a pending one
      if (fire) begin
        pend[c] = 1'b1;
        pend_code[c] = code;
        mask_left[c] = (hold_cfg == 0) ? 8'd1 : hold_cfg;
      end
    end
    if (t.drain) begin
      for (int c = 0; c < NumChannels; c++) begin
        if (pend[c]) begin
          ev.channel_id = ChanIdW'(c);
          ev.event_type = pend_code[c];
          ev.last       = 1'b0;
          fired_now.push_back(ev);
          pend[c] = 1'b0;
          pend_code[c] = '0;
        end
      end
      if (fired_now.size() != 0) fired_now[fired_now.size()-1].last = 1'b1;
    end
  endfunction

  // offer one tick, then book what it should report
  task automatic send_tick(input tick_t t, input bit typed, input int unsigned n_exp,
                           input result_t exp_ev);
    int unsigned g;
    g = pick_gap();
    if (g != 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push   <= 1'b1;
    tick_i <= t;
    do @(posedge clk_i); while (full);
    advance_tick(t);
    ticks_sent++;
    if (t.drain) drains++;
    if (typed) begin
      if (n_exp != 0) event_q.push_back(exp_ev);
    end else begin
      foreach (fired_now[i]) event_q.push_back(fired_now[i]);
    end
  endtask

  // register write, only once the unit has gone quiet
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    push <= 1'b0;
    while (event_q.size() != 0) @(posedge clk_i);
    repeat (LatencyPad) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_reg_write(idx, data);
    cfg_writes++;
  endtask

  // result side: random pop gaps, one long hold-off on request
  initial begin
    int unsigned g;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        g = PressureHold;
        hold_req = 1'b0;
      end else begin
        g = pick_gap();
      end
      if (g != 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
    end
  end

  // compare each popped event with the oldest booked one
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (event_q.size() == 0) begin
        report_mismatch($sformatf("event ch %0d type %0d with nothing booked",
                                  result_o.channel_id, result_o.event_type));
      end else begin
        want_ev = event_q.pop_front();
        checked++;
        if (result_o.channel_id !== want_ev.channel_id)
          report_mismatch($sformatf("channel_id %0d, booked %0d",
                                    result_o.channel_id, want_ev.channel_id));
        if (result_o.event_type !== want_ev.event_type)
          report_mismatch($sformatf("event_type %0d, booked %0d (ch %0d)",
                                    result_o.event_type, want_ev.event_type,
                                    want_ev.channel_id));
        if (result_o.last !== want_ev.last)
          report_mismatch($sformatf("last %0b, booked %0b (ch %0d)",
                                    result_o.last, want_ev.last, want_ev.channel_id));
      end
    end
  end

  // watchdog and back-pressure count
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && push && full) full_stalls++;
    if (cycles > CycleLimit) begin
      $display("cycle limit of %0d reached", CycleLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [CfgDataW-1:0]          sel_w;
    logic [NumChannels*ModeW-1:0] mode_w;
    logic [NumPins-1:0]           lv;
    int unsigned                  n_ticks;
    int unsigned                  rand_done;
    int unsigned                  phase;
    int unsigned                  r;
    tick_t                        tk;

    // directed table
    dir_rows.push_back('{RowTick, RegNone, '0, {34'h0, 1'b1}, 1'b1, 0, '0});
    dir_rows.push_back('{RowCfg, RegHoldoff, 36'd0, '0, 1'b0, 0, '0});
    dir_rows.push_back('{RowCfg, RegEnable, 36'h01, '0, 1'b0, 0, '0});
    dir_rows.push_back('{RowTick, RegNone, '0, {34'h0, 1'b1}, 1'b1, 1, {3'd0, EvLow, 1'b1}});
    dir_rows.push_back('{RowTick, RegNone, '0, {34'h0, 1'b0}, 1'b1, 0, '0});
    dir_rows.push_back('{RowTick, RegNone, '0, {AllPins, 1'b1}, 1'b1, 1,
                         {3'd0, EvLow, 1'b1}});
    dir_rows.push_back('{RowCfg, RegModes,
                         {18'd0, ModeBad, ModeFall, ModeRise, ModeChange, ModeHigh, ModeLow},
                         '0, 1'b0, 0, '0});
    dir_rows.push_back('{RowCfg, RegPinSelect,
                         {6'd63, 6'd3, 6'd2, 6'd1, 6'd33, 6'd0}, '0, 1'b0, 0, '0});
    dir_rows.push_back('{RowCfg, RegEnable, 36'h3F, '0, 1'b0, 0, '0});
    dir_rows.push_back('{RowTick, RegNone, '0, {AllPins, 1'b1}, 1'b0, 0, '0});
    dir_rows.push_back('{RowTick, RegNone, '0, {34'h0, 1'b0}, 1'b0, 0, '0});
    dir_rows.push_back('{RowTick, RegNone, '0, {34'h2_AAAA_AAAA, 1'b1}, 1'b0, 0, '0});
    dir_rows.push_back('{RowTick, RegNone, '0, {34'h1_5555_5555, 1'b0}, 1'b0, 0, '0});
    dir_rows.push_back('{RowTick, RegNone, '0, {34'h0, 1'b1}, 1'b0, 0, '0});
    dir_rows.push_back('{RowCfg, RegHoldoff, 36'd16, '0, 1'b0, 0, '0});
    dir_rows.push_back('{RowTick, RegNone, '0, {AllPins, 1'b1}, 1'b0, 0, '0});
    dir_rows.push_back('{RowTick, RegNone, '0, {34'h0, 1'b1}, 1'b0, 0, '0});
    dir_rows.push_back('{RowCfg, RegNone, '1, '0, 1'b0, 0, '0});
    dir_rows.push_back('{RowCfg, RegPinSelect, '1, '0, 1'b0, 0, '0});
    dir_rows.push_back('{RowCfg, RegModes, 36'h3FFFF, '0, 1'b0, 0, '0});
    dir_rows.push_back('{RowTick, RegNone, '0, {AllPins, 1'b1}, 1'b1, 0, '0});
    // let the long holdoffs run out with every mode undefined
    dir_rows.push_back('{RowRun, RegNone, 36'd17, {34'h0, 1'b0}, 1'b0, 0, '0});
    dir_rows.push_back('{RowCfg, RegEnable, 36'h00, '0, 1'b0, 0, '0});
    dir_rows.push_back('{RowTick, RegNone, '0, {34'h0, 1'b1}, 1'b1, 0, '0});

    // reset
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      unique case (dir_rows[i].kind)
        RowCfg:  write_reg(dir_rows[i].idx, dir_rows[i].data);
        RowTick: send_tick(dir_rows[i].tk, dir_rows[i].typed, dir_rows[i].n_exp,
                           dir_rows[i].exp_ev);
        RowRun: begin
          repeat (dir_rows[i].data) send_tick(dir_rows[i].tk, 1'b0, 0, '0);
        end
        default: ;
      endcase
    end

    // random phases: fresh settings, then a run of ticks
    rand_done = 0;
    phase = 0;
    while (rand_done < RandomTicks) begin
      steady = (phase % 3 == 2);
      for (int c = 0; c < NumChannels; c++) begin
        sel_w[c*PinIdxW +: PinIdxW] = ($urandom_range(99) < 10) ?
                                      PinIdxW'($urandom_range(NumPins, PinSpan - 1)) :
                                      PinIdxW'($urandom_range(NumPins - 1));
        mode_w[c*ModeW +: ModeW] = ($urandom_range(99) < 10) ?
                                   ModeW'($urandom_range(5, 7)) :
                                   ModeW'($urandom_range(4));
      end
      write_reg(RegPinSelect, sel_w);
      write_reg(RegModes, CfgDataW'(mode_w));
      r = $urandom_range(99);
      write_reg(RegHoldoff, (r < 60) ? CfgDataW'($urandom_range(1, 4)) :
                            (r < 80) ? '0 : CfgDataW'($urandom_range(5, 12)));
      write_reg(RegEnable, ($urandom_range(99) < 70) ? CfgDataW'(6'h3F) :
                           CfgDataW'($urandom_range(63)));
      n_ticks = $urandom_range(10, 22);
      lv = rand_levels();
      for (int k = 0; k < n_ticks; k++) begin
        r = $urandom_range(99);
        if (r < 40) lv = lv ^ (rand_levels() & rand_levels() & rand_levels());
        else if (r < 80) lv = rand_levels();
        tk.pin_levels = lv;
        tk.drain = (k == n_ticks - 1) || ($urandom_range(99) < 30);
        send_tick(tk, 1'b0, 0, '0);
      end
      rand_done += n_ticks;
      phase++;
    end

    // back-pressure: every channel fires each tick while the reader holds off
    steady = 1'b0;
    write_reg(RegPinSelect, {NumChannels{6'd5}});
    write_reg(RegModes, CfgDataW'({NumChannels{ModeHigh}}));
    write_reg(RegHoldoff, '0);
    write_reg(RegEnable, CfgDataW'(6'h3F));
    hold_req = 1'b1;
    repeat (14) send_tick({AllPins, 1'b1}, 1'b0, 0, '0);

    // longest holdoff: one firing, then every channel stays masked
    write_reg(RegHoldoff, CfgDataW'(255));
    repeat (4) send_tick({AllPins, 1'b1}, 1'b0, 0, '0);

    // wind down
    push <= 1'b0;
    while (event_q.size() != 0) @(posedge clk_i);
    repeat (LatencyPad) @(posedge clk_i);

    $display("ran %0d ticks (%0d with drain) under %0d register writes",
             ticks_sent, drains, cfg_writes);
    $display("checked %0d events; input held off by full on %0d cycles",
             checked, full_stalls);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
sv/piu_pkg.sv
sv/piu_front.sv
sv/piu_job_queue.sv
sv/piu_emitter.sv
sv/pin_interrupt_event_unit.sv
sim/tb_pin_interrupt_event_unit.sv
